>>> sv/ftphp_pkg.sv
// Package: shared types and constants for the FTP host-port text parser.
`timescale 1ns / 1ps

package ftphp_pkg;

   typedef enum logic [1:0] {
      PH_SKIP = 2'd0,
      PH_NUM  = 2'd1,
      PH_DONE = 2'd2,
      PH_ERR  = 2'd3
   } phase_type;

   localparam logic [7:0] SEP_CHAR   = 8'h2C;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;
   localparam logic [3:0] MIN_LEN    = 4'd11;
   localparam logic [2:0] LAST_FIELD = 3'd5;
   localparam logic [2:0] PORT_FIELD = 3'd4;

endpackage

>>> sv/ftp_host_port_parser.sv
// Top level: FTP host-port text parser (a,b,c,d,p1,p2), one byte per beat.
// The result of a text is registered and presented in the cycle after its final byte is taken.
// Throughput: one byte per cycle; the parse state is a short update between registers.
// Any byte stalls while the result register is full and not being taken.
// Reset (synchronous, active high) clears parse state and the result valid flag.
// After every result the parse state returns to its reset values for the next text.
`timescale 1ns / 1ps

module ftp_host_port_parser
   import ftphp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_addr_valid,
   output logic [31:0] rsp_ipv4_addr,
   output logic [15:0] rsp_tcp_port
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  field_ff, field_in;
   logic [15:0] acc_ff, acc_in;
   logic [31:0] octets_ff, octets_in;
   logic [7:0]  port_hi_ff, port_hi_in;
   logic [3:0]  len_ff, len_in;
   logic        has_digit_ff, has_digit_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        addr_valid_ff, addr_valid_in;
   logic [31:0] ipv4_ff, ipv4_in;
   logic [15:0] port_ff, port_in;

   logic        beat;
   logic        final_beat;
   logic        is_digit;
   logic [3:0]  digit;
   logic [15:0] acc_step;
   logic        ok;

   // state after this byte but before the end-of-text clear
   logic [3:0]  len_pre_w;
   phase_type   phase_pre_w;
   logic [2:0]  field_pre_w;
   logic [15:0] acc_pre_w;
   logic [31:0] octets_pre_w;
   logic [7:0]  port_hi_pre_w;
   logic        digit_pre_w;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign beat       = req_valid && req_ready;
   assign final_beat = beat && req_final_byte;

   assign is_digit = (req_text_byte >= DIGIT_LO) && (req_text_byte <= DIGIT_HI);
   assign digit    = req_text_byte[3:0];
   // acc*10 + d, mod 2^16
   assign acc_step = {acc_ff[12:0], 3'b000} + {acc_ff[14:0], 1'b0} + {12'd0, digit};

   always_comb begin
      len_pre_w     = (len_ff < MIN_LEN) ? len_ff + 4'd1 : len_ff;
      phase_pre_w   = phase_ff;
      field_pre_w   = field_ff;
      acc_pre_w     = acc_ff;
      octets_pre_w  = octets_ff;
      port_hi_pre_w = port_hi_ff;
      digit_pre_w   = has_digit_ff;
      if (phase_ff == PH_DONE || phase_ff == PH_ERR) begin
         phase_pre_w = phase_ff;
      end else if (req_text_byte == 8'd0) begin
         phase_pre_w = PH_ERR;
      end else if (phase_ff == PH_SKIP) begin
         if (is_digit) begin
            phase_pre_w = PH_NUM;
            field_pre_w = 3'd0;
            acc_pre_w   = {12'd0, digit};
            digit_pre_w = 1'b1;
         end
      end else if (is_digit) begin
         acc_pre_w   = acc_step;
         digit_pre_w = 1'b1;
      end else if (!has_digit_ff) begin
         phase_pre_w = PH_ERR;
      end else if (field_ff >= LAST_FIELD) begin
         phase_pre_w = PH_DONE;
      end else if (req_text_byte != SEP_CHAR) begin
         phase_pre_w = PH_ERR;
      end else begin
         if (field_ff < PORT_FIELD) begin
            octets_pre_w = {octets_ff[23:0], acc_ff[7:0]};
         end else begin
            port_hi_pre_w = acc_ff[7:0];
         end
         field_pre_w = field_ff + 3'd1;
         acc_pre_w   = 16'd0;
         digit_pre_w = 1'b0;
      end
   end

   // parse state update
   always_comb begin
      phase_in     = phase_ff;
      field_in     = field_ff;
      acc_in       = acc_ff;
      octets_in    = octets_ff;
      port_hi_in   = port_hi_ff;
      len_in       = len_ff;
      has_digit_in = has_digit_ff;
      if (beat) begin
         if (req_final_byte) begin
            phase_in     = PH_SKIP;
            field_in     = 3'd0;
            acc_in       = 16'd0;
            octets_in    = 32'd0;
            port_hi_in   = 8'd0;
            len_in       = 4'd0;
            has_digit_in = 1'b0;
         end else begin
            phase_in     = phase_pre_w;
            field_in     = field_pre_w;
            acc_in       = acc_pre_w;
            octets_in    = octets_pre_w;
            port_hi_in   = port_hi_pre_w;
            len_in       = len_pre_w;
            has_digit_in = digit_pre_w;
         end
      end
   end

   // result formation, from the state as updated by this beat
   always_comb begin
      ok = (len_pre_w >= MIN_LEN) &&
           (phase_pre_w == PH_DONE ||
            (phase_pre_w == PH_NUM && field_pre_w == LAST_FIELD && digit_pre_w));
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      addr_valid_in = addr_valid_ff;
      ipv4_in       = ipv4_ff;
      port_in       = port_ff;
      if (final_beat) begin
         rsp_valid_in  = 1'b1;
         addr_valid_in = ok;
         ipv4_in       = ok ? octets_pre_w : 32'd0;
         port_in       = ok ? ({port_hi_pre_w, 8'd0} + acc_pre_w) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         field_ff     <= 3'd0;
         acc_ff       <= 16'd0;
         octets_ff    <= 32'd0;
         port_hi_ff   <= 8'd0;
         len_ff       <= 4'd0;
         has_digit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         field_ff     <= field_in;
         acc_ff       <= acc_in;
         octets_ff    <= octets_in;
         port_hi_ff   <= port_hi_in;
         len_ff       <= len_in;
         has_digit_ff <= has_digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_valid_ff <= addr_valid_in;
      ipv4_ff       <= ipv4_in;
      port_ff       <= port_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_addr_valid = addr_valid_ff;
   assign rsp_ipv4_addr  = ipv4_ff;
   assign rsp_tcp_port   = port_ff;

   // a final beat always lands in the result register
   a_final_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      final_beat |=> rsp_valid)
      else $error("final beat did not produce a result");

   // parse state is back at reset after each text
   a_clear_after_text: assert property (@(posedge clock) disable iff (reset)
      final_beat |=> (phase_ff == PH_SKIP && len_ff == 4'd0 && field_ff == 3'd0))
      else $error("parse state not cleared after final beat");

   // an invalid result carries zero address and port
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_addr_valid) |-> (rsp_ipv4_addr == 32'd0 && rsp_tcp_port == 16'd0))
      else $error("invalid result with nonzero payload");

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      field_ff <= LAST_FIELD)
      else $error("field index out of range");

endmodule
